// ===== rtl/core/svpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpg_pkg: shared types and constants of the video pixel generator
// Raster geometry, register indexes, the queued cell record and colour helpers.
// ----------------------------------------------------------------------------
package svpg_pkg;

  // Raster geometry in character cells and lines
  localparam int unsigned BORDER_LEFT_CELLS  = 4;
  localparam int unsigned BORDER_RIGHT_CELLS = 4;
  localparam int unsigned BORDER_TOP_ROWS    = 48;
  localparam int unsigned BORDER_BOTTOM_ROWS = 48;
  localparam int unsigned SCREEN_COLS        = 32;
  localparam int unsigned SCREEN_LINES       = 192;
  localparam int unsigned LINE_CELLS  = BORDER_LEFT_CELLS + SCREEN_COLS + BORDER_RIGHT_CELLS;
  localparam int unsigned FRAME_LINES = BORDER_TOP_ROWS + SCREEN_LINES + BORDER_BOTTOM_ROWS;

  // Widths of state and ports
  localparam int unsigned COL_W   = 6;
  localparam int unsigned LINE_W  = 9;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Fixed upper address bits: bitmap at 0x4000, attributes at 0x5800
  localparam logic [1:0] BITMAP_HI = 2'b10;
  localparam logic [4:0] ATTR_HI   = 5'b10110;

  // Colour levels
  localparam logic [7:0] LEVEL_NORMAL = 8'hC0;
  localparam logic [7:0] LEVEL_BRIGHT = 8'hFF;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_CELL  = 1'b1
  } op_e;

  typedef enum logic {
    CFG_BORDER_COLOR = 1'b0,
    CFG_FLASH_PERIOD = 1'b1
  } cfg_idx_e;

  // One classified cell waiting for serialisation
  typedef struct packed {
    logic [2:0]        ink;
    logic [2:0]        paper;
    logic              bright;
    logic [7:0]        bitmap;
    logic              next_in_screen;
    logic [ADDR_W-1:0] next_bitmap_addr;
    logic [ADDR_W-1:0] next_attr_addr;
  } cell_t;

  // Level of one colour channel
  function automatic logic [7:0] chan_level(input logic on, input logic bright);
    logic [7:0] lvl;
    lvl = bright ? LEVEL_BRIGHT : LEVEL_NORMAL;
    return on ? lvl : 8'h00;
  endfunction

endpackage

// ===== rtl/core/spectrum_video_pixel_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_video_pixel_generator_unit: character-cell video pixel generator
// The cell is written into the cell queue; its first pixel then leaves through the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the
//   pixel serialiser; frame items give no pixels.
// A two-cell queue lets input run up to two cells ahead of the output.
// Reset (async, active low): raster at line 0 column 0, flash cleared,
//   border colour 1, flash period 15, queue and output empty.
// ----------------------------------------------------------------------------
module spectrum_video_pixel_generator_unit import svpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [7:0]        bitmap_i,
  input  logic [7:0]        attribute_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic              last_o,
  output logic              next_in_screen_o,
  output logic [ADDR_W-1:0] next_bitmap_addr_o,
  output logic [ADDR_W-1:0] next_attr_addr_o
);

  logic  accept;
  logic  push;
  cell_t push_cell;
  logic  full;
  logic  not_empty;
  logic  pop;
  cell_t head;

  // Accept while the queue has room
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  svpg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .op_i        (op_i),
    .bitmap_i    (bitmap_i),
    .attribute_i (attribute_i),
    .push_o      (push),
    .cell_o      (push_cell)
  );

  svpg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cell),
    .pop_i       (pop),
    .full_o      (full),
    .not_empty_o (not_empty),
    .head_o      (head)
  );

  svpg_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (not_empty),
    .head_i             (head),
    .pop_o              (pop),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .red_o              (red_o),
    .green_o            (green_o),
    .blue_o             (blue_o),
    .last_o             (last_o),
    .next_in_screen_o   (next_in_screen_o),
    .next_bitmap_addr_o (next_bitmap_addr_o),
    .next_attr_addr_o   (next_attr_addr_o)
  );

endmodule

// ===== rtl/core/svpg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpg_front: raster walker and cell classifier
// Tracks raster position and flash state, decodes each cell into colours and
// next fetch addresses, and pushes the record into the cell queue.
// ----------------------------------------------------------------------------
module svpg_front import svpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             accept_i,
  input  logic             op_i,
  input  logic [7:0]       bitmap_i,
  input  logic [7:0]       attribute_i,
  output logic             push_o,
  output cell_t            cell_o
);

  logic [2:0]        border_color_q;
  logic [7:0]        flash_period_q;
  logic [7:0]        flash_cnt_q, flash_cnt_d;
  logic              flash_phase_q, flash_phase_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [LINE_W-1:0] line_q, line_d;

  logic              cur_screen;
  logic              nxt_screen;
  logic [COL_W:0]    col_inc;
  logic [LINE_W:0]   line_inc;
  logic [COL_W-1:0]  ncol;
  logic [LINE_W-1:0] nline;
  logic [LINE_W-1:0] y;
  logic [COL_W-1:0]  x;
  logic [7:0]        cnt_inc;
  logic [2:0]        ink, paper;

  // Classify the current cell
  assign cur_screen = (line_q >= LINE_W'(BORDER_TOP_ROWS)) &&
                      (line_q <  LINE_W'(BORDER_TOP_ROWS + SCREEN_LINES)) &&
                      (col_q  >= COL_W'(BORDER_LEFT_CELLS)) &&
                      (col_q  <  COL_W'(BORDER_LEFT_CELLS + SCREEN_COLS));

  // Advance the raster by one cell, wrapping at line and frame end
  always_comb begin
    col_inc  = {1'b0, col_q} + 1'b1;
    line_inc = {1'b0, line_q} + 1'b1;
    if (col_inc >= (COL_W+1)'(LINE_CELLS)) begin
      ncol = '0;
      if (line_inc >= (LINE_W+1)'(FRAME_LINES)) begin
        nline = '0;
      end else begin
        nline = line_inc[LINE_W-1:0];
      end
    end else begin
      ncol  = col_inc[COL_W-1:0];
      nline = line_q;
    end
  end

  assign nxt_screen = (nline >= LINE_W'(BORDER_TOP_ROWS)) &&
                      (nline <  LINE_W'(BORDER_TOP_ROWS + SCREEN_LINES)) &&
                      (ncol  >= COL_W'(BORDER_LEFT_CELLS)) &&
                      (ncol  <  COL_W'(BORDER_LEFT_CELLS + SCREEN_COLS));

  assign y = nline - LINE_W'(BORDER_TOP_ROWS);
  assign x = ncol - COL_W'(BORDER_LEFT_CELLS);

  // Decode ink and paper, swapping them under flash
  always_comb begin
    if (attribute_i[7] && flash_phase_q) begin
      ink   = attribute_i[5:3];
      paper = attribute_i[2:0];
    end else begin
      ink   = attribute_i[2:0];
      paper = attribute_i[5:3];
    end
  end

  // Build the queued record
  always_comb begin
    cell_o = '0;
    cell_o.bitmap         = bitmap_i;
    cell_o.next_in_screen = nxt_screen;
    if (cur_screen) begin
      cell_o.ink    = ink;
      cell_o.paper  = paper;
      cell_o.bright = attribute_i[6];
    end else begin
      cell_o.ink    = border_color_q;
      cell_o.paper  = border_color_q;
      cell_o.bright = 1'b0;
    end
    if (nxt_screen) begin
      cell_o.next_bitmap_addr = {BITMAP_HI, y[7:6], y[2:0], y[5:3], x[4:0]};
      cell_o.next_attr_addr   = {ATTR_HI, y[7:3], x[4:0]};
    end
  end

  assign push_o = accept_i && (op_e'(op_i) == OP_CELL);

  // Next position and flash state
  always_comb begin
    cnt_inc       = flash_cnt_q + 8'd1;
    col_d         = col_q;
    line_d        = line_q;
    flash_cnt_d   = flash_cnt_q;
    flash_phase_d = flash_phase_q;
    if (accept_i) begin
      if (op_e'(op_i) == OP_FRAME) begin
        col_d  = '0;
        line_d = '0;
        if (cnt_inc > flash_period_q) begin
          flash_cnt_d   = '0;
          flash_phase_d = ~flash_phase_q;
        end else begin
          flash_cnt_d = cnt_inc;
        end
      end else begin
        col_d  = ncol;
        line_d = nline;
      end
    end
  end

  // Hold state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_color_q <= 3'd1;
      flash_period_q <= 8'd15;
      flash_cnt_q    <= '0;
      flash_phase_q  <= 1'b0;
      col_q          <= '0;
      line_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_BORDER_COLOR: border_color_q <= cfg_data_i[2:0];
          CFG_FLASH_PERIOD: flash_period_q <= cfg_data_i[7:0];
          default:          ;
        endcase
      end
      flash_cnt_q   <= flash_cnt_d;
      flash_phase_q <= flash_phase_d;
      col_q         <= col_d;
      line_q        <= line_d;
    end
  end

endmodule

// ===== rtl/core/svpg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpg_queue: short cell queue
// Two-entry FIFO between the classifier and the pixel serialiser.
// ----------------------------------------------------------------------------
module svpg_queue import svpg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cell_t push_data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  not_empty_o,
  output cell_t head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cell_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/svpg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpg_back: pixel serialiser
// Emits the eight pixels of the head cell, MSB first, through an output register.
// ----------------------------------------------------------------------------
module svpg_back import svpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  cell_t             head_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic              last_o,
  output logic              next_in_screen_o,
  output logic [ADDR_W-1:0] next_bitmap_addr_o,
  output logic [ADDR_W-1:0] next_attr_addr_o
);

  logic       out_valid_q;
  logic [2:0] pix_idx_q;
  logic       emit;
  logic       last_pix;
  logic [2:0] colour;

  // Emit when a cell waits and the output register is free or being taken
  assign emit     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last_pix = (pix_idx_q == 3'd7);
  assign pop_o    = emit && last_pix;
  assign colour   = head_i.bitmap[3'd7 - pix_idx_q] ? head_i.ink : head_i.paper;

  // Advance the pixel index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pix_idx_q   <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        pix_idx_q   <= pix_idx_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the pixel payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      red_o              <= chan_level(colour[1], head_i.bright);
      green_o            <= chan_level(colour[2], head_i.bright);
      blue_o             <= chan_level(colour[0], head_i.bright);
      last_o             <= last_pix;
      next_in_screen_o   <= head_i.next_in_screen;
      next_bitmap_addr_o <= head_i.next_bitmap_addr;
      next_attr_addr_o   <= head_i.next_attr_addr;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sim/tb_spectrum_video_pixel_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: spectrum_video_pixel_generator_unit
// Drives frame and cell transactions through the valid/stall input, with
// random source gaps and sink stalls. A scoreboard tracks the raster position,
// the flash state and the registers, predicts the eight pixels of each cell,
// and checks every pixel field in order. Register settings change between
// phases while the block is idle. Frames restart the raster often, so the run
// stays in the upper border lines and exercises the flash counter and wrap.
// ----------------------------------------------------------------------------
module tb_spectrum_video_pixel_generator_unit;
  import svpg_pkg::*;

  localparam int unsigned BITMAP_BASE   = 16384;
  localparam int unsigned ATTR_BASE     = 16384 + 6144;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned REPORT_LIMIT  = 40;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;
    logic              next_in_screen;
    logic [ADDR_W-1:0] next_bitmap_addr;
    logic [ADDR_W-1:0] next_attr_addr;
  } pixel_t;

  // Raster tracker and pixel checker
  class pixel_scoreboard;
    logic [2:0]  border_color;
    logic [7:0]  flash_period;
    logic [7:0]  flash_count;
    logic        flash_phase;
    int unsigned row;
    int unsigned col;
    pixel_t      pending_pixels[$];
    int unsigned errors;
    int unsigned transactions;
    int unsigned frames;
    int unsigned screen_cells;
    int unsigned pixels_checked;

    function new();
      border_color   = 3'd1;
      flash_period   = 8'd15;
      flash_count    = '0;
      flash_phase    = 1'b0;
      row            = 0;
      col            = 0;
      errors         = 0;
      transactions   = 0;
      frames         = 0;
      screen_cells   = 0;
      pixels_checked = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [7:0] value);
      if (idx == CFG_BORDER_COLOR) begin
        border_color = value[2:0];
      end else begin
        flash_period = value;
      end
    endfunction

    function bit in_screen(int unsigned r, int unsigned c);
      return r >= BORDER_TOP_ROWS && r < BORDER_TOP_ROWS + SCREEN_LINES &&
             c >= BORDER_LEFT_CELLS && c < BORDER_LEFT_CELLS + SCREEN_COLS;
    endfunction

    function logic [7:0] intensity(logic on, logic bright);
      if (!on) return 8'h00;
      return bright ? 8'hFF : 8'hC0;
    endfunction

    // Advance the raster for one accepted transaction and queue its pixels
    function void advance_raster(op_e kind, logic [7:0] bm, logic [7:0] at);
      logic [2:0]        ink;
      logic [2:0]        paper;
      logic [2:0]        colour;
      logic              bright;
      logic              nscreen;
      int unsigned       ncol;
      int unsigned       nrow;
      int unsigned       x;
      int unsigned       y;
      int                k;
      logic [ADDR_W-1:0] baddr;
      logic [ADDR_W-1:0] aaddr;
      pixel_t            px;
      transactions++;
      if (kind == OP_FRAME) begin
        frames++;
        row = 0;
        col = 0;
        flash_count = flash_count + 8'd1;
        if (flash_count > flash_period) begin
          flash_count = '0;
          flash_phase = ~flash_phase;
        end
        return;
      end
      // Classify the current cell
      if (in_screen(row, col)) begin
        screen_cells++;
        ink    = at[2:0];
        paper  = at[5:3];
        bright = at[6];
        if (at[7] && flash_phase) begin
          colour = ink;
          ink    = paper;
          paper  = colour;
        end
      end else begin
        ink    = border_color;
        paper  = border_color;
        bright = 1'b0;
      end
      // Step to the next cell, wrapping at line and frame ends
      ncol = col + 1;
      nrow = row;
      if (ncol >= LINE_CELLS) begin
        ncol = 0;
        nrow++;
        if (nrow >= FRAME_LINES) nrow = 0;
      end
      col = ncol;
      row = nrow;
      // Fetch addresses of the next cell, interleaved by thirds
      nscreen = in_screen(nrow, ncol);
      baddr   = '0;
      aaddr   = '0;
      if (nscreen) begin
        y = nrow - BORDER_TOP_ROWS;
        x = ncol - BORDER_LEFT_CELLS;
        baddr = ADDR_W'(BITMAP_BASE + ((y & 'hC0) << 5) + ((y & 'h07) << 8) +
                        ((y & 'h38) << 2) + x);
        aaddr = ADDR_W'(ATTR_BASE + (y >> 3) * SCREEN_COLS + x);
      end
      // Leftmost pixel from bitmap bit 7
      for (k = 7; k >= 0; k--) begin
        colour              = bm[k] ? ink : paper;
        px.red              = intensity(colour[1], bright);
        px.green            = intensity(colour[2], bright);
        px.blue             = intensity(colour[0], bright);
        px.last             = (k == 0);
        px.next_in_screen   = nscreen;
        px.next_bitmap_addr = baddr;
        px.next_attr_addr   = aaddr;
        pending_pixels.push_back(px);
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        // Keep the log short when the block is badly off
        if (errors <= REPORT_LIMIT) begin
          $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $error("pixel transaction with no cell pending");
        return;
      end
      want = pending_pixels.pop_front();
      compare("red", 32'(want.red), 32'(got.red));
      compare("green", 32'(want.green), 32'(got.green));
      compare("blue", 32'(want.blue), 32'(got.blue));
      compare("last", 32'(want.last), 32'(got.last));
      compare("next_in_screen", 32'(want.next_in_screen), 32'(got.next_in_screen));
      compare("next_bitmap_addr", 32'(want.next_bitmap_addr),
              32'(got.next_bitmap_addr));
      compare("next_attr_addr", 32'(want.next_attr_addr), 32'(got.next_attr_addr));
    endfunction
  endclass

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cfg_we     = 1'b0;
  logic              cfg_idx    = 1'b0;
  logic [CFG_W-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic              op         = 1'b0;
  logic [7:0]        bitmap     = '0;
  logic [7:0]        attribute  = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              last;
  logic              next_in_screen;
  logic [ADDR_W-1:0] next_bitmap_addr;
  logic [ADDR_W-1:0] next_attr_addr;

  bit                calm       = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       cycles     = 0;
  int unsigned       settings   = 0;
  pixel_scoreboard   sb;

  spectrum_video_pixel_generator_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .op_i               (op),
    .bitmap_i           (bitmap),
    .attribute_i        (attribute),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .red_o              (red),
    .green_o            (green),
    .blue_o             (blue),
    .last_o             (last),
    .next_in_screen_o   (next_in_screen),
    .next_bitmap_addr_o (next_bitmap_addr),
    .next_attr_addr_o   (next_attr_addr)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the pixel output in random bursts
  always @(posedge clk_i) begin
    if (calm || !rst_ni) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every accepted pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_pixel('{red, green, blue, last, next_in_screen,
                       next_bitmap_addr, next_attr_addr});
    end
  end

  // Give up on a hung block
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_spectrum_video_pixel_generator_unit: errors");
      $finish;
    end
  end

  // Present one transaction, hold it until accepted, then predict it
  task automatic send_item(op_e kind, logic [7:0] bm, logic [7:0] at);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    op        <= kind;
    bitmap    <= bm;
    attribute <= at;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.advance_raster(kind, bm, at);
  endtask

  task automatic send_frame();
    send_item(OP_FRAME, 8'($urandom), 8'($urandom));
  endtask

  task automatic run_cells(int unsigned n);
    repeat (n) send_item(OP_CELL, 8'($urandom), 8'($urandom));
  endtask

  // Wait until all pixels are out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [7:0] border_data, logic [7:0] period_data);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_BORDER_COLOR;
    cfg_data <= border_data;
    @(posedge clk_i);
    cfg_idx  <= CFG_FLASH_PERIOD;
    cfg_data <= period_data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.set_register(CFG_BORDER_COLOR, border_data);
    sb.set_register(CFG_FLASH_PERIOD, period_data);
    settings++;
  endtask

  // Mostly frames followed by a short cell burst; some frame-only runs
  task automatic random_run();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 9);
    if (pick <= 6) begin
      n = $urandom_range(1, 3);
      repeat (n) send_frame();
      run_cells($urandom_range(1, 50));
    end else if (pick <= 8) begin
      n = $urandom_range(0, 2);
      repeat (n) send_frame();
      run_cells($urandom_range(1, 20));
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) send_frame();
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Border cells under the reset register values
    send_item(OP_CELL, 8'h00, 8'h00);
    send_item(OP_CELL, 8'hFF, 8'hFF);

    // Border colour 7 via masked upper bits, flash toggling on every frame
    configure(8'hFF, 8'h00);
    send_item(OP_CELL, 8'h80, 8'h01);
    send_item(OP_CELL, 8'h01, 8'h80);
    send_frame();
    send_frame();
    send_frame();
    // Border cells ignore bitmap and attribute whatever the flash phase
    send_item(OP_CELL, 8'hAA, 8'h87);
    send_item(OP_CELL, 8'h55, 8'hC5);
    send_item(OP_CELL, 8'h0F, 8'hFF);
    send_item(OP_CELL, 8'hF0, 8'h47);
    send_frame();
    repeat (3) random_run();

    // Black border, flash period at maximum so the phase holds
    configure(8'hF8, 8'hFF);
    repeat (10) send_frame();
    repeat (3) random_run();

    configure(8'($urandom), 8'h01);
    repeat (3) random_run();

    configure(8'h01, 8'h0F);
    repeat (10) send_frame();
    repeat (2) random_run();

    // No idling from here: back-to-back cells, then more runs
    configure(8'($urandom), 8'($urandom));
    calm = 1'b1;
    send_frame();
    run_cells(LINE_CELLS + $urandom_range(1, 20));
    repeat (2) random_run();

    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions (%0d frame starts, %0d screen cells) over %0d settings",
             sb.transactions, sb.frames, sb.screen_cells, settings);
    $display("Checked %0d pixels of border cells with flash counter updates in between",
             sb.pixels_checked);
    if (sb.errors == 0) begin
      $display("tb_spectrum_video_pixel_generator_unit: clean");
    end else begin
      $display("tb_spectrum_video_pixel_generator_unit: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/svpg_pkg.sv
rtl/core/svpg_front.sv
rtl/core/svpg_queue.sv
rtl/core/svpg_back.sv
rtl/core/spectrum_video_pixel_generator_unit.sv
sim/tb_spectrum_video_pixel_generator_unit.sv
